[design/tsd_pkg.sv]
// types and constants shared by the tar stream deframer
`default_nettype none

package tsd_pkg;

  localparam int unsigned BLOCK_BYTES = 512;
  localparam int unsigned BLK_BITS    = 9;
  localparam int unsigned SIZE_W      = 36;
  localparam int unsigned MODE_W      = 24;
  localparam int unsigned SKIP_W      = SIZE_W + 1;
  localparam int unsigned FILES_W     = 16;

  localparam logic [BLK_BITS-1:0] HDR_NAME_END  = 9'd100;
  localparam logic [BLK_BITS-1:0] HDR_MODE_END  = 9'd108;
  localparam logic [BLK_BITS-1:0] HDR_SIZE_BEG  = 9'd124;
  localparam logic [BLK_BITS-1:0] HDR_SIZE_END  = 9'd136;
  localparam logic [BLK_BITS-1:0] HDR_TYPE_AT   = 9'd156;
  localparam logic [BLK_BITS-1:0] HDR_LAST      = 9'(BLOCK_BYTES - 1);

  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_DIR   = 8'h35;
  localparam logic [4:0] OCT_HIGH = 5'b00110;

  typedef enum logic [2:0] {
    KIND_NAME     = 3'd0,
    KIND_HEADER   = 3'd1,
    KIND_DATA     = 3'd2,
    KIND_ZERO_END = 3'd3,
    KIND_TRUNC    = 3'd4
  } kind_e;

  typedef enum logic [1:0] {
    CLS_REGULAR = 2'd0,
    CLS_DIR     = 2'd1,
    CLS_OTHER   = 2'd2
  } class_e;

  typedef enum logic [1:0] {
    PH_HEADER = 2'd0,
    PH_DATA   = 2'd1,
    PH_SKIP   = 2'd2,
    PH_DONE   = 2'd3
  } phase_e;

  typedef struct packed {
    kind_e               kind;
    logic [7:0]          out_byte;
    class_e              entry_class;
    logic [SIZE_W-1:0]   entry_size;
    logic [MODE_W-1:0]   entry_mode;
    logic                last_data;
    logic [FILES_W-1:0]  files_seen;
  } result_t;

endpackage

`default_nettype wire

[design/tsd_stream_if.sv]
// request channels of the tar stream deframer
`default_nettype none

interface tsd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_value;
  logic       first_of_archive;

  modport source (output valid, output byte_value, output first_of_archive, input ready);
  modport sink   (input valid, input byte_value, input first_of_archive, output ready);
endinterface

interface tsd_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic [7:0]  out_byte;
  logic [1:0]  entry_class;
  logic [35:0] entry_size;
  logic [23:0] entry_mode;
  logic        last_data;
  logic [15:0] files_seen;

  modport source (output valid, output kind, output out_byte, output entry_class,
                  output entry_size, output entry_mode, output last_data,
                  output files_seen, input ready);
  modport sink   (input valid, input kind, input out_byte, input entry_class,
                  input entry_size, input entry_mode, input last_data,
                  input files_seen, output ready);
endinterface

`default_nettype wire

[design/tar_stream_deframer.sv]
// top level of the tar stream deframer: input stage, parser and result register
//
//  channel  dir  carries                                         handshake
//  in_i     in   byte_value, first_of_archive                    valid/ready
//  out_o    out  kind, out_byte, entry_class, entry_size,        valid/ready
//                entry_mode, last_data, files_seen
//  cfg      in   archive_length via cfg_wdata_i                  cfg_we_i only
//
// one byte per cycle sustained while out_o is not stalled; each request is held in the input stage,
// is parsed there and any result it yields lands in the output register
// while a result waits the input stage takes one more request, then input stalls
// reset clears the parse state to header phase and archive_length to zero
`default_nettype none

module tar_stream_deframer #(
  parameter int unsigned LENGTH_BITS = 40,
  parameter int unsigned COUNT_BITS  = 16
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  tsd_in_if.sink                 in_i,
  tsd_out_if.source              out_o,
  input  logic                   cfg_we_i,
  input  logic [LENGTH_BITS-1:0] cfg_wdata_i
);

  logic [LENGTH_BITS-1:0] len_q;
  logic                   s1_valid_q;
  logic [7:0]             s1_byte_q;
  logic                   s1_first_q;
  logic                   out_valid_q;
  tsd_pkg::result_t       out_q;
  logic                   step;
  logic                   res_valid;
  tsd_pkg::result_t       res;

  assign step       = s1_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !s1_valid_q || step;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q <= '0;
    end else if (cfg_we_i) begin
      len_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_i.valid && in_i.ready) begin
      s1_valid_q <= 1'b1;
    end else if (step) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      s1_byte_q  <= in_i.byte_value;
      s1_first_q <= in_i.first_of_archive;
    end
  end

  tsd_parser #(
    .LENGTH_BITS (LENGTH_BITS),
    .COUNT_BITS  (COUNT_BITS)
  ) u_parser (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .step_i           (step),
    .byte_i           (s1_byte_q),
    .first_i          (s1_first_q),
    .archive_length_i (len_q),
    .res_valid_o      (res_valid),
    .res_o            (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (step && res_valid) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step && res_valid) begin
      out_q <= res;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.kind        = out_q.kind;
  assign out_o.out_byte    = out_q.out_byte;
  assign out_o.entry_class = out_q.entry_class;
  assign out_o.entry_size  = out_q.entry_size;
  assign out_o.entry_mode  = out_q.entry_mode;
  assign out_o.last_data   = out_q.last_data;
  assign out_o.files_seen  = out_q.files_seen;

endmodule

`default_nettype wire

[design/tsd_parser.sv]
// per-byte parse state and result decode of the tar stream deframer
`default_nettype none

module tsd_parser #(
  parameter int unsigned LENGTH_BITS = 40,
  parameter int unsigned COUNT_BITS  = 16
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   step_i,
  input  logic [7:0]             byte_i,
  input  logic                   first_i,
  input  logic [LENGTH_BITS-1:0] archive_length_i,
  output logic                   res_valid_o,
  output tsd_pkg::result_t       res_o
);

  tsd_pkg::phase_e                 phase_q, phase_d, phase_c;
  logic [tsd_pkg::BLK_BITS-1:0]    hoff_q, hoff_d, hoff_c;
  logic [LENGTH_BITS-1:0]          aoff_q, aoff_d, aoff_c;
  logic [tsd_pkg::SIZE_W-1:0]      size_q, size_d, size_c;
  logic                            sopen_q, sopen_d, sopen_c;
  logic [tsd_pkg::MODE_W-1:0]      mode_q, mode_d, mode_c;
  logic                            mopen_q, mopen_d, mopen_c;
  logic                            nopen_q, nopen_d, nopen_c;
  logic [7:0]                      type_q, type_d, type_c;
  logic [tsd_pkg::SIZE_W-1:0]      dl_q, dl_d, dl_c;
  logic [tsd_pkg::SKIP_W-1:0]      sk_q, sk_d, sk_c;
  logic [COUNT_BITS-1:0]           cnt_q, cnt_d, cnt_c;

  logic                            clr;
  logic                            octal;
  logic                            hdr_past_end;
  logic                            data_past_end;
  logic [LENGTH_BITS-1:0]          size_ext;
  logic [tsd_pkg::BLK_BITS-1:0]    pad_fill;
  logic [tsd_pkg::SIZE_W-tsd_pkg::BLK_BITS:0] pad_blocks;
  tsd_pkg::class_e                 cls;
  tsd_pkg::kind_e                  kind;
  logic [7:0]                      obyte;
  tsd_pkg::class_e                 ocls;
  logic                            last;

  always_comb begin
    phase_c = first_i ? tsd_pkg::PH_HEADER : phase_q;
    hoff_c  = first_i ? '0 : hoff_q;
    aoff_c  = first_i ? '0 : aoff_q;
    dl_c    = first_i ? '0 : dl_q;
    sk_c    = first_i ? '0 : sk_q;
    cnt_c   = first_i ? '0 : cnt_q;

    // entry fields start afresh on a restart and at every header start
    clr     = first_i || (phase_c == tsd_pkg::PH_HEADER && hoff_c == '0);
    size_c  = clr ? '0 : size_q;
    sopen_c = clr ? 1'b1 : sopen_q;
    mode_c  = clr ? '0 : mode_q;
    mopen_c = clr ? 1'b1 : mopen_q;
    nopen_c = clr ? 1'b1 : nopen_q;
    type_c  = clr ? '0 : type_q;

    octal    = (byte_i[7:3] == tsd_pkg::OCT_HIGH);
    size_ext = LENGTH_BITS'(size_c);
    pad_fill = tsd_pkg::BLK_BITS'(0) - size_c[tsd_pkg::BLK_BITS-1:0];
    pad_blocks = {1'b0, size_c[tsd_pkg::SIZE_W-1:tsd_pkg::BLK_BITS]}
               + (tsd_pkg::SIZE_W - tsd_pkg::BLK_BITS + 1)'(|size_c[tsd_pkg::BLK_BITS-1:0]);

    hdr_past_end  = (archive_length_i < LENGTH_BITS'(tsd_pkg::BLOCK_BYTES))
                 || (aoff_c > archive_length_i - LENGTH_BITS'(tsd_pkg::BLOCK_BYTES));
    data_past_end = (size_ext > archive_length_i)
                 || (aoff_c >= archive_length_i - size_ext);

    if (type_c == tsd_pkg::CH_DIR) begin
      cls = tsd_pkg::CLS_DIR;
    end else if (type_c == tsd_pkg::CH_ZERO || type_c == 8'd0) begin
      cls = tsd_pkg::CLS_REGULAR;
    end else begin
      cls = tsd_pkg::CLS_OTHER;
    end

    phase_d = phase_c;
    hoff_d  = hoff_c;
    aoff_d  = aoff_c;
    size_d  = size_c;
    sopen_d = sopen_c;
    mode_d  = mode_c;
    mopen_d = mopen_c;
    nopen_d = nopen_c;
    type_d  = type_c;
    dl_d    = dl_c;
    sk_d    = sk_c;
    cnt_d   = cnt_c;

    res_valid_o = 1'b0;
    kind        = tsd_pkg::KIND_NAME;
    obyte       = '0;
    ocls        = tsd_pkg::CLS_REGULAR;
    last        = 1'b0;

    unique case (phase_c)
      tsd_pkg::PH_DATA: begin
        aoff_d      = aoff_c + 1'b1;
        dl_d        = dl_c - 1'b1;
        res_valid_o = 1'b1;
        kind        = tsd_pkg::KIND_DATA;
        obyte       = byte_i;
        last        = (dl_d == '0);
        if (last) begin
          phase_d = (sk_c != '0) ? tsd_pkg::PH_SKIP : tsd_pkg::PH_HEADER;
        end
      end
      tsd_pkg::PH_SKIP: begin
        aoff_d = aoff_c + 1'b1;
        sk_d   = sk_c - 1'b1;
        if (sk_d == '0) begin
          phase_d = tsd_pkg::PH_HEADER;
        end
      end
      tsd_pkg::PH_HEADER: begin
        aoff_d = aoff_c + 1'b1;
        if (hoff_c == '0 && hdr_past_end) begin
          phase_d     = tsd_pkg::PH_DONE;
          res_valid_o = 1'b1;
          kind        = tsd_pkg::KIND_TRUNC;
        end else if (hoff_c == '0 && byte_i == 8'd0) begin
          phase_d     = tsd_pkg::PH_DONE;
          res_valid_o = 1'b1;
          kind        = tsd_pkg::KIND_ZERO_END;
        end else begin
          if (hoff_c < tsd_pkg::HDR_NAME_END) begin
            if (nopen_c) begin
              if (byte_i == 8'd0) begin
                nopen_d = 1'b0;
              end else begin
                res_valid_o = 1'b1;
                kind        = tsd_pkg::KIND_NAME;
                obyte       = byte_i;
              end
            end
          end else if (hoff_c < tsd_pkg::HDR_MODE_END) begin
            if (mopen_c && octal) begin
              mode_d = {mode_c[tsd_pkg::MODE_W-4:0], byte_i[2:0]};
            end else begin
              mopen_d = 1'b0;
            end
          end else if (hoff_c >= tsd_pkg::HDR_SIZE_BEG && hoff_c < tsd_pkg::HDR_SIZE_END) begin
            if (sopen_c && octal) begin
              size_d = {size_c[tsd_pkg::SIZE_W-4:0], byte_i[2:0]};
            end else begin
              sopen_d = 1'b0;
            end
          end else if (hoff_c == tsd_pkg::HDR_TYPE_AT) begin
            type_d = byte_i;
          end

          if (hoff_c != tsd_pkg::HDR_LAST) begin
            hoff_d = hoff_c + 1'b1;
          end else begin
            hoff_d      = '0;
            res_valid_o = 1'b1;
            if (cls == tsd_pkg::CLS_REGULAR && data_past_end) begin
              phase_d = tsd_pkg::PH_DONE;
              kind    = tsd_pkg::KIND_TRUNC;
            end else begin
              kind = tsd_pkg::KIND_HEADER;
              ocls = cls;
              if (cls == tsd_pkg::CLS_REGULAR) begin
                if (cnt_c != '1) begin
                  cnt_d = cnt_c + 1'b1;
                end
                dl_d = size_c;
                sk_d = tsd_pkg::SKIP_W'(pad_fill);
                if (size_c != '0) begin
                  phase_d = tsd_pkg::PH_DATA;
                end else begin
                  phase_d = (pad_fill != '0) ? tsd_pkg::PH_SKIP : tsd_pkg::PH_HEADER;
                end
              end else begin
                dl_d    = '0;
                sk_d    = {pad_blocks, tsd_pkg::BLK_BITS'(0)};
                phase_d = (size_c != '0) ? tsd_pkg::PH_SKIP : tsd_pkg::PH_HEADER;
              end
            end
          end
        end
      end
      tsd_pkg::PH_DONE: begin
      end
      default: begin
      end
    endcase

    res_o.kind        = kind;
    res_o.out_byte    = obyte;
    res_o.entry_class = ocls;
    res_o.entry_size  = size_d;
    res_o.entry_mode  = mode_d;
    res_o.last_data   = last;
    res_o.files_seen  = tsd_pkg::FILES_W'(cnt_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= tsd_pkg::PH_HEADER;
      hoff_q  <= '0;
      aoff_q  <= '0;
      size_q  <= '0;
      sopen_q <= 1'b1;
      mode_q  <= '0;
      mopen_q <= 1'b1;
      nopen_q <= 1'b1;
      type_q  <= '0;
      dl_q    <= '0;
      sk_q    <= '0;
      cnt_q   <= '0;
    end else if (step_i) begin
      phase_q <= phase_d;
      hoff_q  <= hoff_d;
      aoff_q  <= aoff_d;
      size_q  <= size_d;
      sopen_q <= sopen_d;
      mode_q  <= mode_d;
      mopen_q <= mopen_d;
      nopen_q <= nopen_d;
      type_q  <= type_d;
      dl_q    <= dl_d;
      sk_q    <= sk_d;
      cnt_q   <= cnt_d;
    end
  end

  a_done_on_boundary: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == tsd_pkg::PH_DONE |-> hoff_q == '0)
    else $error("stopped parse left mid header");

  a_data_left_live: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == tsd_pkg::PH_DATA |-> dl_q != '0)
    else $error("data phase with nothing left");

  a_skip_left_live: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == tsd_pkg::PH_SKIP |-> sk_q != '0)
    else $error("skip phase with nothing left");

  a_count_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && !first_i |=> cnt_q >= $past(cnt_q))
    else $error("file count went backwards");

  a_last_is_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && res_valid_o && res_o.last_data |-> res_o.kind == tsd_pkg::KIND_DATA)
    else $error("last marker on a non-data request");

endmodule

`default_nettype wire
